@@ rtl/ofp_pkg.sv @@
`default_nettype none
package ofp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned SCALE_W     = 24;
  localparam int unsigned SCALED_W    = 40;
  localparam int unsigned PAY_BYTES   = 6;
  localparam int unsigned PAY_IDX_W   = 3;
  localparam int unsigned OUT_DATA_W  = 136;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [BYTE_W-1:0]  HDR_SYNC   = 8'hFE;
  localparam logic [BYTE_W-1:0]  HDR_LEN    = 8'h04;
  localparam logic [BYTE_W-1:0]  FTR_BYTE   = 8'hAA;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd59056;

  // Register index 0 sits at byte address 0; bit 2 of the address selects the index.
  localparam logic REG_FLOW_SCALE = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] quality;
    logic [WORD_W-1:0] range_cm;
    logic [WORD_W-1:0] flow_y_counts;
    logic [WORD_W-1:0] flow_x_counts;
  } ofp_frame_t;

endpackage
`default_nettype wire

@@ rtl/ofp_cfg_regs.sv @@
`default_nettype none
module ofp_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [ofp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [ofp_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [ofp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready,
  output logic      [ofp_pkg::SCALE_W-1:0]       flow_scale
);
  import ofp_pkg::*;

  logic [SCALE_W-1:0] flow_scale_r;
  logic               wr_en;
  logic               sel_scale;

  assign cfg_pready = 1'b1;
  assign sel_scale  = (cfg_paddr[2] == REG_FLOW_SCALE);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & sel_scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_scale_r <= SCALE_RST;
    end else if (wr_en) begin
      flow_scale_r <= cfg_pwdata[SCALE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_scale) begin
      cfg_prdata = {{(CFG_DATA_W-SCALE_W){1'b0}}, flow_scale_r};
    end
  end

  assign flow_scale = flow_scale_r;

endmodule
`default_nettype wire

@@ rtl/ofp_frame_fsm.sv @@
`default_nettype none
module ofp_frame_fsm (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [ofp_pkg::BYTE_W-1:0]   rx_byte,
  output logic                              frame_done,
  output ofp_pkg::ofp_frame_t               frame
);
  import ofp_pkg::*;

  typedef enum logic [3:0] {
    ST_HUNT = 4'd0,
    ST_SYNC = 4'd1,
    ST_PAY0 = 4'd2,
    ST_PAY1 = 4'd3,
    ST_PAY2 = 4'd4,
    ST_PAY3 = 4'd5,
    ST_PAY4 = 4'd6,
    ST_PAY5 = 4'd7,
    ST_CKSM = 4'd8,
    ST_QUAL = 4'd9,
    ST_FOOT = 4'd10,
    ST_DONE = 4'd11
  } state_t;

  state_t                state_r, state_nxt;
  logic [PAY_IDX_W-1:0]  payload_count_r, payload_count_nxt;
  logic [BYTE_W-1:0]     quality_hold_r, quality_hold_nxt;
  logic [BYTE_W-1:0]     payload_store_r [PAY_BYTES];
  logic                  store_wr;
  logic [BYTE_W-1:0]     cksum;
  logic                  in_payload;
  logic                  done_nxt;

  assign in_payload = (state_r >= ST_PAY0) && (state_r <= ST_PAY5);

  always_comb begin
    cksum = '0;
    for (int i = 0; i < PAY_BYTES; i++) begin
      cksum = cksum + payload_store_r[i];
    end
  end

  always_comb begin
    state_nxt         = state_r;
    payload_count_nxt = payload_count_r;
    quality_hold_nxt  = quality_hold_r;
    store_wr          = 1'b0;
    done_nxt          = 1'b0;
    unique case (state_r)
      ST_SYNC: begin
        state_nxt = (rx_byte == HDR_LEN) ? ST_PAY0 : ST_HUNT;
      end
      ST_PAY0, ST_PAY1, ST_PAY2, ST_PAY3, ST_PAY4, ST_PAY5: begin
        // A count past the last entry drops the byte; it cannot happen in a
        // well-formed run but keeps the store write in range.
        if (payload_count_r < PAY_IDX_W'(PAY_BYTES)) begin
          store_wr          = 1'b1;
          payload_count_nxt = payload_count_r + 1'b1;
        end
        state_nxt = state_t'(state_r + 4'd1);
      end
      ST_CKSM: begin
        state_nxt         = (cksum == rx_byte) ? ST_QUAL : ST_HUNT;
        payload_count_nxt = '0;
      end
      ST_QUAL: begin
        quality_hold_nxt = rx_byte;
        state_nxt        = ST_FOOT;
      end
      ST_FOOT: begin
        if (rx_byte == FTR_BYTE) begin
          state_nxt = ST_DONE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      default: begin
        // Hunting, a just-finished frame and unused codes all look for a header.
        state_nxt = (rx_byte == HDR_SYNC) ? ST_SYNC : ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_HUNT;
      payload_count_r <= '0;
      quality_hold_r  <= '0;
    end else if (step) begin
      state_r         <= state_nxt;
      payload_count_r <= payload_count_nxt;
      quality_hold_r  <= quality_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_wr) begin
      payload_store_r[payload_count_r] <= rx_byte;
    end
  end

  assign frame_done             = step & done_nxt;
  assign frame.flow_x_counts    = {payload_store_r[1], payload_store_r[0]};
  assign frame.flow_y_counts    = {payload_store_r[3], payload_store_r[2]};
  assign frame.range_cm         = {payload_store_r[5], payload_store_r[4]};
  assign frame.quality          = quality_hold_r;

  // The payload count tracks the position within the payload bytes.
  a_count_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload |-> (4'(payload_count_r) == 4'(state_r - ST_PAY0)))
    else $error("payload count out of step with frame state");

  a_cksum_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step && state_r == ST_CKSM) |=> (payload_count_r == '0))
    else $error("payload count not cleared after checksum byte");

  a_done_enters_done: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> (state_r == ST_DONE))
    else $error("good footer did not end the frame");

endmodule
`default_nettype wire

@@ rtl/ofp_out_stage.sv @@
`default_nettype none
module ofp_out_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire ofp_pkg::ofp_frame_t              frame,
  input  wire logic [ofp_pkg::SCALE_W-1:0]      flow_scale,
  input  wire logic                             out_tready,
  output logic                                  out_tvalid,
  output logic      [ofp_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import ofp_pkg::*;

  logic                        out_valid_r;
  logic [OUT_DATA_W-1:0]       out_data_r;
  logic signed [SCALED_W-1:0]  cnt_x_s;
  logic signed [SCALED_W-1:0]  cnt_y_s;
  logic signed [SCALED_W-1:0]  scale_s;
  logic [SCALED_W-1:0]         prod_x;
  logic [SCALED_W-1:0]         prod_y;

  // Counts are sign-extended and the unsigned gain zero-extended to the result
  // width, so the low bits of the product are the exact two's complement value.
  assign cnt_x_s = $signed({{(SCALED_W-WORD_W){frame.flow_x_counts[WORD_W-1]}},
                            frame.flow_x_counts});
  assign cnt_y_s = $signed({{(SCALED_W-WORD_W){frame.flow_y_counts[WORD_W-1]}},
                            frame.flow_y_counts});
  assign scale_s = $signed({{(SCALED_W-SCALE_W){1'b0}}, flow_scale});
  assign prod_x  = cnt_x_s * scale_s;
  assign prod_y  = cnt_y_s * scale_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {frame.quality, frame.range_cm,
                     prod_y, prod_x,
                     frame.flow_y_counts, frame.flow_x_counts};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ rtl/optical_flow_frame_parser.sv @@
`default_nettype none
// Parses a byte stream from an optical flow sensor: header 0xFE 0x04, six payload
// bytes (x motion, y motion, distance; 16 bits each, low byte first), an 8-bit sum
// checksum, a quality byte and footer 0xAA. One item of the output stream is sent
// per good frame, on its footer. The block takes one byte per clock while it does
// not stall: a byte is captured in an input register, the frame state machine steps
// on it once the output register is free or being taken, and a finished frame is
// written to the output register together with the two 16x24 gain products.
// The input stalls only while the output register holds an item not yet taken and
// the input register is also full. The user must write flow_scale (address 0) only
// while no byte is in flight; the block itself does not enforce this.
module optical_flow_frame_parser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,    // [7:0] rx_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [15:0] flow_x_counts, [31:16] flow_y_counts, [71:32] flow_x_scaled,
  // [111:72] flow_y_scaled, [127:112] range_cm, [135:128] quality
  output logic      [ofp_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [ofp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [ofp_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [ofp_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);
  import ofp_pkg::*;

  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               can_out;
  logic               step;
  logic               in_fire;
  logic               frame_done;
  ofp_frame_t         frame;
  logic [SCALE_W-1:0] flow_scale;

  assign can_out   = ~out_tvalid | out_tready;
  assign step      = in_valid_r & can_out;
  assign in_tready = ~in_valid_r | can_out;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
    end
  end

  ofp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .flow_scale  (flow_scale)
  );

  ofp_frame_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (in_byte_r),
    .frame_done (frame_done),
    .frame      (frame)
  );

  ofp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (frame_done),
    .frame      (frame),
    .flow_scale (flow_scale),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // The input side stalls only when both the input and output registers are full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without a held result");

  // A completed frame always shows up on the output in the next cycle.
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> out_tvalid)
    else $error("completed frame missing from output");

  // A held byte never waits while the output can take a result.
  a_no_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && can_out) |=> (!in_valid_r || $past(in_fire)))
    else $error("input register held a byte without stepping");

endmodule
`default_nettype wire

@@ tb/sv/optical_flow_frame_parser_tb.sv @@
`default_nettype none
module optical_flow_frame_parser_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 400;
  localparam int NUM_PHASES    = 5;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 17;
  localparam int DIR_ROWS      = 25;
  localparam int MAX_REPORTS   = 10;

  localparam logic [ofp_pkg::CFG_ADDR_W-1:0] FLOW_SCALE_ADDR = {ofp_pkg::REG_FLOW_SCALE, 2'b00};

  typedef enum logic [3:0] {
    ST_HUNT = 4'd0,
    ST_SYNC = 4'd1,
    ST_PAY0 = 4'd2,
    ST_PAY5 = 4'd7,
    ST_CKSM = 4'd8,
    ST_QUAL = 4'd9,
    ST_FOOT = 4'd10,
    ST_DONE = 4'd11
  } parse_state_t;

  typedef enum int {FR_GOOD, FR_BAD_LEN, FR_BAD_SUM, FR_BAD_FOOT} frame_kind_t;

  // Declared from the top bit down, so flow_x_counts lands in out_tdata[15:0].
  typedef struct packed {
    logic [7:0]  quality;
    logic [15:0] range_cm;
    logic [39:0] flow_y_scaled;
    logic [39:0] flow_x_scaled;
    logic [15:0] flow_y_counts;
    logic [15:0] flow_x_counts;
  } flow_frame_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    flow_frame_t want;
  } dir_row_t;

  localparam flow_frame_t NO_FRAME = '0;
  // Unit x, minus one y, full range and quality, at the reset gain of 59056.
  localparam flow_frame_t WANT_UNIT = {8'hFF, 16'hFFFF, 40'hFFFFFF1950, 40'h000000E6B0,
                                       16'hFFFF, 16'h0001};
  // Most negative x, most positive y, zero range and quality, at the reset gain.
  localparam flow_frame_t WANT_EXTREME = {8'h00, 16'h0000, 40'h0073571950, 40'hFF8CA80000,
                                          16'h7FFF, 16'h8000};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [ofp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [ofp_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [ofp_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [ofp_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  optical_flow_frame_parser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state mirrored from the block.
  logic [3:0]  p_state = ST_HUNT;
  logic [7:0]  p_store [6];
  logic [2:0]  p_count = '0;
  logic [7:0]  p_quality = '0;
  logic [23:0] flow_gain = ofp_pkg::SCALE_RST;

  flow_frame_t want_frames [$];
  int          mismatches = 0;
  int          frames_checked = 0;
  int          bytes_sent = 0;
  int          gains_written = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        calm = 1'b0;
  flow_frame_t seen_frame;
  flow_frame_t oldest_frame;

  task automatic flag(input string what, input logic [39:0] want, input logic [39:0] seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", what, want, seen);
  endtask

  function automatic logic [39:0] scale_count(input logic [15:0] cnt);
    logic signed [39:0] cnt_s;
    logic signed [39:0] gain_s;
    cnt_s  = $signed({{24{cnt[15]}}, cnt});
    gain_s = $signed({16'h0000, flow_gain});
    return cnt_s * gain_s;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, output bit done,
                                     output flow_frame_t fr);
    logic [7:0] sum;
    done = 1'b0;
    fr = NO_FRAME;
    sum = '0;
    if (p_state == ST_HUNT || p_state >= ST_DONE) begin
      // Hunting and the state after a good footer both treat 0xFE as a header.
      p_state = (b == ofp_pkg::HDR_SYNC) ? ST_SYNC : ST_HUNT;
    end else if (p_state == ST_SYNC) begin
      p_state = (b == ofp_pkg::HDR_LEN) ? ST_PAY0 : ST_HUNT;
    end else if (p_state <= ST_PAY5) begin
      if (p_count < 3'd6) begin
        p_store[p_count] = b;
        p_count = p_count + 3'd1;
      end
      p_state = p_state + 4'd1;
    end else if (p_state == ST_CKSM) begin
      for (int i = 0; i < 6; i++) sum = sum + p_store[i];
      p_state = (sum == b) ? ST_QUAL : ST_HUNT;
      p_count = '0;
    end else if (p_state == ST_QUAL) begin
      p_quality = b;
      p_state = ST_FOOT;
    end else if (b != ofp_pkg::FTR_BYTE) begin
      p_state = ST_HUNT;
    end else begin
      p_state = ST_DONE;
      done = 1'b1;
      fr.flow_x_counts = {p_store[1], p_store[0]};
      fr.flow_y_counts = {p_store[3], p_store[2]};
      fr.range_cm      = {p_store[5], p_store[4]};
      fr.quality       = p_quality;
      fr.flow_x_scaled = scale_count(fr.flow_x_counts);
      fr.flow_y_scaled = scale_count(fr.flow_y_counts);
    end
  endfunction

  task automatic compare_frame(input flow_frame_t want, input flow_frame_t seen);
    if (seen.flow_x_counts !== want.flow_x_counts)
      flag("flow_x_counts", 40'(want.flow_x_counts), 40'(seen.flow_x_counts));
    if (seen.flow_y_counts !== want.flow_y_counts)
      flag("flow_y_counts", 40'(want.flow_y_counts), 40'(seen.flow_y_counts));
    if (seen.flow_x_scaled !== want.flow_x_scaled)
      flag("flow_x_scaled", want.flow_x_scaled, seen.flow_x_scaled);
    if (seen.flow_y_scaled !== want.flow_y_scaled)
      flag("flow_y_scaled", want.flow_y_scaled, seen.flow_y_scaled);
    if (seen.range_cm !== want.range_cm)
      flag("range_cm", 40'(want.range_cm), 40'(seen.range_cm));
    if (seen.quality !== want.quality)
      flag("quality", 40'(want.quality), 40'(seen.quality));
  endtask

  // Valid stays high from one item to the next unless an idle cycle is drawn.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    bit          done;
    flow_frame_t fr;
    send_byte(b);
    parse_byte(b, done, fr);
    if (done) want_frames.push_back(fr);
  endtask

  function automatic logic [15:0] pick_word();
    unique case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic emit_frame(input frame_kind_t kind);
    logic [15:0] w [3];
    logic [7:0]  sum;
    logic [7:0]  qual;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      w[i] = pick_word();
      sum = sum + w[i][7:0] + w[i][15:8];
    end
    qual = 8'($urandom_range(255));
    feed(ofp_pkg::HDR_SYNC);
    if (kind == FR_BAD_LEN) begin
      feed(ofp_pkg::HDR_LEN ^ 8'($urandom_range(255, 1)));
      return;
    end
    feed(ofp_pkg::HDR_LEN);
    for (int i = 0; i < 3; i++) begin
      feed(w[i][7:0]);
      feed(w[i][15:8]);
    end
    feed(kind == FR_BAD_SUM ? sum ^ 8'($urandom_range(255, 1)) : sum);
    feed(qual);
    feed(kind == FR_BAD_FOOT ? ofp_pkg::FTR_BYTE ^ 8'($urandom_range(255, 1))
                             : ofp_pkg::FTR_BYTE);
  endtask

  task automatic emit_noise();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) feed(($urandom_range(3) == 0) ? ofp_pkg::HDR_SYNC : 8'($urandom_range(255)));
  endtask

  // Stop offering, wait for every frame to come out, then let in-flight bytes settle.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (want_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [23:0] g);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= FLOW_SCALE_ADDR;
    cfg_pwdata  <= {8'h00, g};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // Read the register back; psel stays high into the next setup cycle.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {8'h00, g})
      flag("flow_scale readback", 40'({8'h00, g}), 40'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    flow_gain = g;
    gains_written++;
  endtask

  // Result side: check each frame taken and decide the next ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_frame = out_tdata;
        if (want_frames.size() == 0) begin
          flag("unexpected result, flow_x_counts", '0, 40'(seen_frame.flow_x_counts));
        end else begin
          oldest_frame = want_frames.pop_front();
          compare_frame(oldest_frame, seen_frame);
          frames_checked++;
          // Two long hold-offs let the sender back the block up.
          if (frames_checked == 25 || frames_checked == 110) hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still expected",
               cycle_count, want_frames.size());
      $display("optical_flow_frame_parser_tb: FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t    dir_table [DIR_ROWS];
    logic [23:0] gains [NUM_PHASES];
    bit          done;
    flow_frame_t fr;
    int          phase_end;
    int          pick;

    dir_table = '{
      {8'hFE, 1'b0, NO_FRAME},
      {8'h04, 1'b0, NO_FRAME},
      {8'h01, 1'b0, NO_FRAME},
      {8'h00, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'hFD, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'hAA, 1'b1, WANT_UNIT},
      // A second frame starts right on the footer of the first.
      {8'hFE, 1'b0, NO_FRAME},
      {8'h04, 1'b0, NO_FRAME},
      {8'h00, 1'b0, NO_FRAME},
      {8'h80, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'h7F, 1'b0, NO_FRAME},
      {8'h00, 1'b0, NO_FRAME},
      {8'h00, 1'b0, NO_FRAME},
      {8'hFE, 1'b0, NO_FRAME},
      {8'h00, 1'b0, NO_FRAME},
      {8'hAA, 1'b1, WANT_EXTREME},
      // Anything but a header after a footer drops back to hunting.
      {8'h00, 1'b0, NO_FRAME},
      {8'hFE, 1'b0, NO_FRAME},
      {8'h05, 1'b0, NO_FRAME}
    };
    gains = '{24'd0, 24'hFFFFFF, 24'd1, 24'd0, ofp_pkg::SCALE_RST};
    gains[3] = 24'($urandom_range(24'hFFFFFF));
    for (int i = 0; i < 6; i++) p_store[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_table[i].rx);
      parse_byte(dir_table[i].rx, done, fr);
      if (dir_table[i].typed) want_frames.push_back(dir_table[i].want);
      else if (done) want_frames.push_back(fr);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      write_gain(gains[p]);
      calm <= (p == 1);
      phase_end = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) emit_frame(FR_GOOD);
        else if (pick < 82) emit_frame(frame_kind_t'($urandom_range(3, 1)));
        else emit_noise();
      end
    end
    drain_block();

    $display("Sent %0d bytes of good, broken and back-to-back frames under %0d gain settings.",
             bytes_sent, gains_written);
    $display("Compared %0d frames field by field; %0d mismatches.", frames_checked, mismatches);
    if (mismatches == 0 && want_frames.size() == 0) begin
      $display("optical_flow_frame_parser_tb: PASS");
    end else begin
      $display("optical_flow_frame_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/ofp_pkg.sv
rtl/ofp_cfg_regs.sv
rtl/ofp_frame_fsm.sv
rtl/ofp_out_stage.sv
rtl/optical_flow_frame_parser.sv
tb/sv/optical_flow_frame_parser_tb.sv
